[design/fpbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbs_pkg
// shared types and constants for the binary64 power-by-squaring block
// ----------------------------------------------------------------------------
package fpbs_pkg;

    localparam logic [63:0] ONE_BITS    = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [10:0] EXP_MAX     = 11'h7FF;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_MUL_WAIT,
        S_DONE
    } t_state;

    // which product the shared multiplier is working on
    typedef enum logic [1:0] {
        OP_ACC,
        OP_SQR,
        OP_FINAL
    } t_op;

    // multiplier status towards the sequencer
    typedef struct packed {
        logic done;
        logic ovf;
        logic ftz;
    } t_mul_status;

endpackage

[design/fpbs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbs_in_if / fpbs_out_if
// valid/ready channels for operand and result beats
// ----------------------------------------------------------------------------
interface fpbs_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] base_bits;
    logic [63:0] exponent;
    modport source (output valid, base_bits, exponent, input ready);
    modport sink   (input valid, base_bits, exponent, output ready);
endinterface

interface fpbs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] power_bits;
    logic        overflowed;
    logic        flushed;
    modport source (output valid, power_bits, overflowed, flushed, input ready);
    modport sink   (input valid, power_bits, overflowed, flushed, output ready);
endinterface

[design/float_power_by_squaring_top.sv]
`timescale 1ns / 1ps
// each binary64 multiply passes through S_DECIDE and S_MUL_WAIT; top set
// bit k needs k squarings plus one multiply per set bit (up to 127 multiplies),
// and exponent 0 goes from S_DECIDE straight to S_DONE with a result of 1.0
// a new operand beat is taken only in S_IDLE, once the last result has left S_DONE;
// one finished result can wait in the output register while the next computes
// reset is synchronous active low and clears the sequencer and valid flag.
// ----------------------------------------------------------------------------
// float_power_by_squaring_top
// binary64 base raised to an unsigned integer power, square-and-multiply
// ----------------------------------------------------------------------------
module float_power_by_squaring_top
    import fpbs_pkg::*;
#(
    parameter int EXP_BITS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fpbs_in_if.sink    in_ch,
    fpbs_out_if.source out_ch
);

    t_state              r_state, n_state;
    logic [63:0]         r_base, r_acc, r_res;
    logic [EXP_BITS-1:0] r_n;
    logic                r_ovf, r_ftz, r_ovalid;
    logic                r_res_ovf, r_res_ftz;
    t_op                 r_op, d_op;
    logic                mul_start, out_free;
    logic [63:0]         mul_a, mul_b, mul_p;
    t_mul_status         mst;

    assign in_ch.ready        = (r_state == S_IDLE);
    assign out_ch.valid       = r_ovalid;
    assign out_ch.power_bits  = r_res;
    assign out_ch.overflowed  = r_res_ovf;
    assign out_ch.flushed     = r_res_ftz;
    assign out_free           = !r_ovalid || out_ch.ready;

    // next step of the exponent walk
    always_comb begin
        if (r_n == EXP_BITS'(1)) begin
            d_op = OP_FINAL;
        end else if (r_n[0]) begin
            d_op = OP_ACC;
        end else begin
            d_op = OP_SQR;
        end
    end

    // operand select for the shared multiplier and sequencer next state
    always_comb begin
        mul_start = 1'b0;
        mul_a = (d_op == OP_SQR) ? r_base : r_acc;
        mul_b = r_base;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_ch.valid) n_state = S_DECIDE;
            S_DECIDE: begin
                mul_start = (r_n != '0);
                n_state = (r_n == '0) ? S_DONE : S_MUL_WAIT;
            end
            S_MUL_WAIT: if (mst.done) n_state = (r_op == OP_FINAL) ? S_DONE : S_DECIDE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    fpbs_fmul u_fmul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_p(mul_p), .o_status(mst)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= (r_state == S_DONE) || (r_ovalid && !out_ch.ready);
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (in_ch.valid) begin
                r_base <= in_ch.base_bits;
                r_n    <= in_ch.exponent[EXP_BITS-1:0];
                r_acc  <= ONE_BITS;
                r_ovf  <= 1'b0;
                r_ftz  <= 1'b0;
            end
            S_DECIDE: r_op <= d_op;
            S_MUL_WAIT: if (mst.done) begin
                r_ovf <= r_ovf | mst.ovf;
                r_ftz <= r_ftz | mst.ftz;
                unique case (r_op)
                    OP_ACC: begin
                        r_acc <= mul_p;
                        r_n   <= r_n & ~EXP_BITS'(1);
                    end
                    OP_SQR: begin
                        r_base <= mul_p;
                        r_n    <= r_n >> 1;
                    end
                    default: r_acc <= mul_p;
                endcase
            end
            S_DONE: if (out_free) begin
                r_res     <= r_acc;
                r_res_ovf <= r_ovf;
                r_res_ftz <= r_ftz;
            end
            default: ;
        endcase
    end

endmodule

[design/fpbs_fmul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbs_fmul
// multi-cycle binary64 multiplier, round to nearest even, flush to zero
// ----------------------------------------------------------------------------
module fpbs_fmul
    import fpbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p,
    output t_mul_status o_status
);

    // phases: 0 settle, 1..4 partial products, 5 normalise, 6 round/pack
    logic [2:0]   r_phase, n_phase;
    logic         r_busy, n_busy;
    logic         r_done;
    logic         r_spec;
    logic [63:0]  r_spec_val;
    logic         r_spec_ftz;
    logic         r_sign;
    logic [12:0]  r_e;
    logic [52:0]  r_ma, r_mb;
    logic [105:0] r_acc;
    logic [63:0]  r_p;
    logic         r_ovf, r_ftz;
    logic [52:0]  r_mant;
    logic         r_guard, r_sticky;
    logic [12:0]  r_en;

    logic [10:0] ea, eb;
    logic [51:0] fa, fb;
    logic        nan_a, nan_b, sub_a, sub_b, z_a, z_b, inf_a, inf_b;

    always_comb begin
        ea = i_a[62:52];
        eb = i_b[62:52];
        fa = i_a[51:0];
        fb = i_b[51:0];
        nan_a = (ea == EXP_MAX) && (fa != '0);
        nan_b = (eb == EXP_MAX) && (fb != '0);
        sub_a = (ea == '0) && (fa != '0);
        sub_b = (eb == '0) && (fb != '0);
        z_a = (ea == '0);
        z_b = (eb == '0);
        inf_a = (ea == EXP_MAX);
        inf_b = (eb == EXP_MAX);
    end

    // special operand classes, resolved when the operands are taken
    logic        spec, spec_ftz;
    logic [63:0] spec_val;
    always_comb begin
        spec     = 1'b1;
        spec_ftz = sub_a || sub_b;
        spec_val = '0;
        if (nan_a) begin
            spec_val = i_a | QUIET_BIT;
            spec_ftz = 1'b0;
        end else if (nan_b) begin
            spec_val = i_b | QUIET_BIT;
            spec_ftz = 1'b0;
        end else if (inf_a || inf_b) begin
            spec_val = (z_a || z_b) ? DEFAULT_NAN
                                    : {i_a[63] ^ i_b[63], EXP_MAX, 52'd0};
        end else if (z_a || z_b) begin
            spec_val = {i_a[63] ^ i_b[63], 63'd0};
        end else begin
            spec = 1'b0;
        end
    end

    // phase 1: a low, b low; 2: a low b high; 3: a high b low; 4: high high
    logic [26:0] qa, qb;
    always_comb begin
        unique case (r_phase)
            3'd1:    begin qa = r_ma[26:0];         qb = r_mb[26:0];         end
            3'd2:    begin qa = r_ma[26:0];         qb = {1'b0, r_mb[52:27]}; end
            3'd3:    begin qa = {1'b0, r_ma[52:27]}; qb = r_mb[26:0];        end
            default: begin qa = {1'b0, r_ma[52:27]}; qb = {1'b0, r_mb[52:27]}; end
        endcase
    end
    logic [53:0] qp;
    assign qp = qa * qb;
    logic [105:0] qp_sh;
    always_comb begin
        unique case (r_phase)
            3'd1:        qp_sh = {52'd0, qp};
            3'd2, 3'd3:  qp_sh = {25'd0, qp, 27'd0};
            default:     qp_sh = {qp[51:0], 54'd0};
        endcase
    end

    // rounding increment and final packing
    logic [53:0] mant_r;
    logic [12:0] ef;
    logic [63:0] pack_p;
    logic        pack_ovf, pack_ftz;
    always_comb begin
        mant_r   = {1'b0, r_mant} + {53'd0, r_guard && (r_sticky || r_mant[0])};
        ef       = mant_r[53] ? r_en + 13'd1 : r_en;
        pack_ovf = 1'b0;
        pack_ftz = r_spec_ftz;
        if (r_spec) begin
            pack_p = r_spec_val;
        end else if (!ef[12] && ef >= 13'd2047) begin
            pack_ovf = 1'b1;
            pack_p   = {r_sign, EXP_MAX, 52'd0};
        end else if (ef[12] || ef == 13'd0) begin
            pack_ftz = 1'b1;
            pack_p   = {r_sign, 63'd0};
        end else begin
            pack_p = {r_sign, ef[10:0], mant_r[53] ? mant_r[52:1] : mant_r[51:0]};
        end
    end

    // control
    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        if (i_start) begin
            n_busy  = 1'b1;
            n_phase = 3'd0;
        end else if (r_busy) begin
            if (r_phase == 3'd6) begin
                n_busy = 1'b0;
            end
            n_phase = r_phase + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_phase <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_phase <= n_phase;
            r_done <= r_busy && !i_start && (r_phase == 3'd6);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sign     <= i_a[63] ^ i_b[63];
            r_spec     <= spec;
            r_spec_val <= spec_val;
            r_spec_ftz <= spec_ftz;
            r_ma <= {1'b1, fa};
            r_mb <= {1'b1, fb};
            r_e <= {2'b0, ea} + {2'b0, eb} - 13'd1023;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_phase >= 3'd1 && r_phase <= 3'd4) begin
                r_acc <= r_acc + qp_sh;
            end
            if (r_phase == 3'd5) begin
                if (r_acc[105]) begin
                    r_mant   <= r_acc[105:53];
                    r_guard  <= r_acc[52];
                    r_sticky <= r_acc[51:0] != '0;
                    r_en     <= r_e + 13'd1;
                end else begin
                    r_mant   <= r_acc[104:52];
                    r_guard  <= r_acc[51];
                    r_sticky <= r_acc[50:0] != '0;
                    r_en     <= r_e;
                end
            end
            if (r_phase == 3'd6) begin
                r_p   <= pack_p;
                r_ovf <= pack_ovf;
                r_ftz <= pack_ftz;
            end
        end
    end

    assign o_p = r_p;
    assign o_status = '{done: r_done, ovf: r_ovf, ftz: r_ftz};

endmodule

[bench/fpbs_power_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbs_power_checker
// watches operand and result beats of the power-by-squaring block, works out
// the expected power with an integer binary64 multiply and compares fields
// ----------------------------------------------------------------------------
module fpbs_power_checker
    import fpbs_pkg::*;
#(
    parameter int EXP_BITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpbs_in_if         in_ch,
    fpbs_out_if        out_ch,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [63:0] power_bits;
        logic        overflowed;
        logic        flushed;
    } t_power;

    t_power expected_powers[$];
    int     fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_powers.size();

    // binary64 multiply, round to nearest even, subnormals flushed
    function automatic logic [63:0] dmul(input logic [63:0] a, input logic [63:0] b,
                                         inout logic ovf, inout logic ftz);
        logic        sgn;
        logic [10:0] ea, eb;
        logic [52:0] ma, mb;
        logic [105:0] prod;
        logic [53:0] mant;
        logic        guard, sticky;
        int          e;
        sgn = a[63] ^ b[63];
        ea = a[62:52];
        eb = b[62:52];
        ma = {1'b0, a[51:0]};
        mb = {1'b0, b[51:0]};
        if (ea == EXP_MAX && ma != 0) return a | QUIET_BIT;
        if (eb == EXP_MAX && mb != 0) return b | QUIET_BIT;
        if (ea == 0 && ma != 0) begin ftz = 1'b1; ma = 0; end
        if (eb == 0 && mb != 0) begin ftz = 1'b1; mb = 0; end
        if (ea == EXP_MAX || eb == EXP_MAX) begin
            if (ea == 0 || eb == 0) return DEFAULT_NAN;
            return {sgn, EXP_MAX, 52'd0};
        end
        if (ea == 0 || eb == 0) return {sgn, 63'd0};
        ma[52] = 1'b1;
        mb[52] = 1'b1;
        prod = ma * mb;
        e = int'(ea) + int'(eb) - 1023;
        if (prod[105]) begin
            e = e + 1;
            mant   = {1'b0, prod[105:53]};
            guard  = prod[52];
            sticky = |prod[51:0];
        end else begin
            mant   = {1'b0, prod[104:52]};
            guard  = prod[51];
            sticky = |prod[50:0];
        end
        if (guard && (sticky || mant[0])) mant = mant + 1;
        if (mant[53]) begin
            mant = mant >> 1;
            e = e + 1;
        end
        if (e >= 2047) begin
            ovf = 1'b1;
            return {sgn, EXP_MAX, 52'd0};
        end
        if (e <= 0) begin
            ftz = 1'b1;
            return {sgn, 63'd0};
        end
        return {sgn, e[10:0], mant[51:0]};
    endfunction

    // square-and-multiply over the used exponent bits
    function automatic t_power predict_power(input logic [63:0] base_in,
                                             input logic [63:0] exp_in);
        t_power      res;
        logic [63:0] n, base, acc;
        logic        ovf, ftz;
        n = (EXP_BITS >= 64) ? exp_in : (exp_in & ((64'd1 << EXP_BITS) - 1));
        base = base_in;
        acc = ONE_BITS;
        ovf = 1'b0;
        ftz = 1'b0;
        if (n == 0) return '{ONE_BITS, 1'b0, 1'b0};
        while (n > 1) begin
            if (n[0]) acc = dmul(acc, base, ovf, ftz);
            base = dmul(base, base, ovf, ftz);
            n = n >> 1;
        end
        acc = dmul(acc, base, ovf, ftz);
        res = '{acc, ovf, ftz};
        return res;
    endfunction

    // operand beats in, result beats checked
    always @(posedge i_clk) begin
        t_power got, want;
        int     errs;
        errs = 0;
        if (!i_rst_n) begin
            fail_count <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                expected_powers.push_back(predict_power(in_ch.base_bits, in_ch.exponent));
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.power_bits, out_ch.overflowed, out_ch.flushed};
                if (expected_powers.size() == 0) begin
                    $display("%0t: result beat with none expected: %h %b %b", $time,
                             got.power_bits, got.overflowed, got.flushed);
                    errs++;
                end else begin
                    want = expected_powers.pop_front();
                    if (got.power_bits !== want.power_bits) begin
                        $display("%0t: power_bits expected %h actual %h", $time,
                                 want.power_bits, got.power_bits);
                        errs++;
                    end
                    if (got.overflowed !== want.overflowed) begin
                        $display("%0t: overflowed expected %b actual %b", $time,
                                 want.overflowed, got.overflowed);
                        errs++;
                    end
                    if (got.flushed !== want.flushed) begin
                        $display("%0t: flushed expected %b actual %b", $time,
                                 want.flushed, got.flushed);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

[bench/tb_float_power_by_squaring_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_float_power_by_squaring_top
// drives base/exponent beats through the power-by-squaring block with random
// gaps and back-pressure; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_float_power_by_squaring_top;
    import fpbs_pkg::*;

    localparam int EXP_BITS   = 64;
    localparam int N_DIRECTED = 24;
    localparam int N_RANDOM   = 450;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending;
    int   src_idle_pct = 0;
    int   snk_stall_pct = 0;
    bit   hold_off = 1'b0;

    fpbs_in_if  in_ch();
    fpbs_out_if out_ch();

    float_power_by_squaring_top #(
        .EXP_BITS(EXP_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    fpbs_power_checker #(
        .EXP_BITS(EXP_BITS)
    ) chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #1 i_clk = ~i_clk;

    // run limit
    initial begin
        #20_000_000;
        $display("[float_power_by_squaring_top] ERROR");
        $finish;
    end

    // result side stalls
    initial out_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        if (hold_off)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // random binary64 pattern, biased towards interesting classes
    function automatic logic [63:0] rand_base();
        logic [63:0] v;
        logic [10:0] e;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0: e = 11'd0;
            1: e = EXP_MAX;
            2: e = 11'(1023 + $urandom_range(2) - 1);
            3: e = 11'($urandom_range(2046, 1));
            default: e = 11'(1023 + $urandom_range(40) - 20);
        endcase
        v[62:52] = e;
        if ($urandom_range(3) == 0) v[51:0] = {4'($urandom_range(15)), 48'd0};
        return v;
    endfunction

    function automatic logic [63:0] rand_exp();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: return v;
            1: return v >> $urandom_range(63);
            default: return 64'($urandom_range(300));
        endcase
    endfunction

    // valid stays up after a beat unless the next one idles first
    task automatic send_beat(input logic [63:0] b, input logic [63:0] n);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.base_bits <= b;
        in_ch.exponent  <= n;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    logic [63:0] dir_base[N_DIRECTED] = '{
        64'h4000_0000_0000_0000, 64'hC000_0000_0000_0000, 64'h7FF4_0000_0000_0001,
        64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
        64'h0010_0000_0000_0000, 64'h3FF0_0000_0000_0001, 64'h3FEF_FFFF_FFFF_FFFF,
        64'h4000_0000_0000_0000, 64'h3FE0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h3FF0_0000_0000_0000, 64'h4008_0000_0000_0000, 64'hBFF8_0000_0000_0000,
        64'h800F_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000, 64'h3FF1_0000_0000_0000,
        64'h4000_0000_0000_0000, 64'h0000_0000_0000_0000, 64'h7FF8_0000_0000_0000};
    logic [63:0] dir_exp[N_DIRECTED] = '{
        64'd10, 64'd3, 64'd5,
        64'd2, 64'd3, 64'd7,
        64'd3, 64'd1, 64'd2,
        64'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
        64'd1024, 64'd1075, 64'd0,
        64'hFFFF_FFFF_FFFF_FFFF, 64'd37, 64'd99,
        64'd1, 64'd0, 64'd1000,
        64'd1, 64'd0, 64'd2};

    // stimulus and verdict
    initial begin
        int guard_cnt;
        in_ch.valid     <= 1'b0;
        in_ch.base_bits <= '0;
        in_ch.exponent  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats
        for (int i = 0; i < N_DIRECTED; i++) send_beat(dir_base[i], dir_exp[i]);

        // long hold-off on the result side so the block fills and stalls input
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 4; i++) send_beat(rand_base(), 64'($urandom_range(20)));
                in_ch.valid <= 1'b0;
            end
        join
        @(posedge i_clk);

        // random beats over idling phases
        for (int i = 0; i < N_RANDOM; i++) begin
            case (i / 90)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 58; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 58; end
                3: begin src_idle_pct = 16; snk_stall_pct = 16; end
                default: begin src_idle_pct = 0; snk_stall_pct = 0; end
            endcase
            send_beat(rand_base(), rand_exp());
        end
        in_ch.valid <= 1'b0;

        // drain
        guard_cnt = 0;
        while (pending != 0 && guard_cnt < 200000) begin
            @(posedge i_clk);
            guard_cnt++;
        end
        repeat (1100) @(posedge i_clk);
        if (pending == 0 && fail_count == 0)
            $display("[float_power_by_squaring_top] OK");
        else
            $display("[float_power_by_squaring_top] ERROR");
        $finish;
    end

endmodule

[filelist.f]
design/fpbs_pkg.sv
design/fpbs_if.sv
design/fpbs_fmul.sv
design/float_power_by_squaring_top.sv
bench/fpbs_power_checker.sv
bench/tb_float_power_by_squaring_top.sv
